// ===== hdl/segi_pkg.sv =====
// Shared types and constants for the segment intersection block.
// Depends on nothing; every other file but segi_fifo refers to it by scoped names.
package segi_pkg;

    localparam int COORD_BITS = 16;
    localparam int DIFF_W     = COORD_BITS + 1;       // endpoint differences
    localparam int LINE_W     = 2 * COORD_BITS + 2;   // line constants c1, c2
    localparam int DET_W      = 2 * COORD_BITS + 3;   // determinant
    localparam int NUM_W      = 3 * COORD_BITS + 4;   // crossing numerators
    localparam int BND_W      = COORD_BITS + DET_W;   // box bound times determinant

    localparam logic [1:0] ST_HIT      = 2'd0;
    localparam logic [1:0] ST_DISJOINT = 2'd1;
    localparam logic [1:0] ST_PARALLEL = 2'd2;
    localparam logic [1:0] ST_OUTSIDE  = 2'd3;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] seg_a_start_x;
        logic signed [COORD_BITS-1:0] seg_a_start_y;
        logic signed [COORD_BITS-1:0] seg_a_end_x;
        logic signed [COORD_BITS-1:0] seg_a_end_y;
        logic signed [COORD_BITS-1:0] seg_b_start_x;
        logic signed [COORD_BITS-1:0] seg_b_start_y;
        logic signed [COORD_BITS-1:0] seg_b_end_x;
        logic signed [COORD_BITS-1:0] seg_b_end_y;
    } t_seg_in;

    typedef struct packed {
        logic        [1:0]            hit_status;
        logic signed [COORD_BITS-1:0] cross_x;
        logic signed [COORD_BITS-1:0] cross_y;
    } t_seg_out;

    // Classified word handed from the front end to the back end.
    typedef struct packed {
        logic        [1:0]            status;
        logic signed [COORD_BITS-1:0] xlo;
        logic signed [COORD_BITS-1:0] xhi;
        logic signed [COORD_BITS-1:0] ylo;
        logic signed [COORD_BITS-1:0] yhi;
        logic signed [DIFF_W-1:0]     a1;
        logic signed [DIFF_W-1:0]     b1;
        logic signed [DIFF_W-1:0]     a2;
        logic signed [DIFF_W-1:0]     b2;
        logic signed [LINE_W-1:0]     c1;
        logic signed [LINE_W-1:0]     c2;
        logic signed [DET_W-1:0]      det;
    } t_mid;

endpackage

// ===== hdl/segi_fifo.sv =====
// Small synchronous first-in first-out queue with show-ahead read.
// Depends on nothing; writers keep it from overflowing by counting credits.
module segi_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4,
    localparam int AW = $clog2(DEPTH),
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_empty,
    output logic [CW-1:0]    o_count
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [AW-1:0]    r_wp;
    logic [AW-1:0]    r_rp;
    logic [CW-1:0]    r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + AW'(1);
            end
            if (i_pop) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + AW'(1);
            end
            r_cnt <= r_cnt + CW'(i_push) - CW'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

    assign o_rdata = r_mem[r_rp];
    assign o_empty = (r_cnt == '0);
    assign o_count = r_cnt;

endmodule

// ===== hdl/segi_front.sv =====
// Front end: takes input words, tests the bounding boxes, forms the line
// equations and the determinant. Depends on segi_pkg.
module segi_front #(
    parameter int MID_DEPTH = 4,
    localparam int CNT_W = $clog2(MID_DEPTH + 1)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  segi_pkg::t_seg_in  i_seg,
    output logic               o_full,
    input  logic [CNT_W-1:0]   i_mid_count,
    output logic               o_mid_push,
    output segi_pkg::t_mid     o_mid
);

    localparam int CB = segi_pkg::COORD_BITS;
    localparam int DW = segi_pkg::DIFF_W;
    localparam int LW = segi_pkg::LINE_W;
    localparam int TW = segi_pkg::DET_W;

    logic              r_v;
    segi_pkg::t_seg_in r_seg;
    logic              accept;
    logic [CNT_W:0]    used;

    logic signed [CB-1:0]      ax1, ay1, ax2, ay2, bx1, by1, bx2, by2;
    logic signed [CB-1:0]      axl, axh, ayl, ayh, bxl, bxh, byl, byh;
    logic signed [CB-1:0]      xlo, xhi, ylo, yhi;
    logic signed [DW-1:0]      a1, b1, a2, b2;
    logic signed [DW+CB-1:0]   p_a1x, p_b1y, p_a2x, p_b2y;
    logic signed [2*DW-1:0]    p_a1b2, p_a2b1;
    logic signed [LW-1:0]      c1, c2;
    logic signed [TW-1:0]      det;
    logic                      disjoint;

    // A slot is held for the word in the input register as well as the
    // words already queued, so nothing is pushed into a full queue.
    assign used   = {1'b0, i_mid_count} + (CNT_W + 1)'(r_v);
    assign o_full = (used >= (CNT_W + 1)'(MID_DEPTH));
    assign accept = i_push && !o_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else begin
            r_v <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_seg <= i_seg;
        end
    end

    always_comb begin
        ax1 = r_seg.seg_a_start_x;
        ay1 = r_seg.seg_a_start_y;
        ax2 = r_seg.seg_a_end_x;
        ay2 = r_seg.seg_a_end_y;
        bx1 = r_seg.seg_b_start_x;
        by1 = r_seg.seg_b_start_y;
        bx2 = r_seg.seg_b_end_x;
        by2 = r_seg.seg_b_end_y;

        axl = (ax1 < ax2) ? ax1 : ax2;
        axh = (ax1 > ax2) ? ax1 : ax2;
        ayl = (ay1 < ay2) ? ay1 : ay2;
        ayh = (ay1 > ay2) ? ay1 : ay2;
        bxl = (bx1 < bx2) ? bx1 : bx2;
        bxh = (bx1 > bx2) ? bx1 : bx2;
        byl = (by1 < by2) ? by1 : by2;
        byh = (by1 > by2) ? by1 : by2;

        xlo = (axl > bxl) ? axl : bxl;
        xhi = (axh < bxh) ? axh : bxh;
        ylo = (ayl > byl) ? ayl : byl;
        yhi = (ayh < byh) ? ayh : byh;
        disjoint = (xlo > xhi) || (ylo > yhi);

        a1 = DW'(ay2) - DW'(ay1);
        b1 = DW'(ax1) - DW'(ax2);
        a2 = DW'(by2) - DW'(by1);
        b2 = DW'(bx1) - DW'(bx2);

        p_a1x = a1 * ax1;
        p_b1y = b1 * ay1;
        p_a2x = a2 * bx1;
        p_b2y = b2 * by1;
        c1    = LW'(p_a1x) + LW'(p_b1y);
        c2    = LW'(p_a2x) + LW'(p_b2y);

        p_a1b2 = a1 * b2;
        p_a2b1 = a2 * b1;
        det    = TW'(p_a1b2) - TW'(p_a2b1);
    end

    always_comb begin
        o_mid.xlo = xlo;
        o_mid.xhi = xhi;
        o_mid.ylo = ylo;
        o_mid.yhi = yhi;
        o_mid.a1  = a1;
        o_mid.b1  = b1;
        o_mid.a2  = a2;
        o_mid.b2  = b2;
        o_mid.c1  = c1;
        o_mid.c2  = c2;
        o_mid.det = det;
        if (disjoint) begin
            o_mid.status = segi_pkg::ST_DISJOINT;
        end else if (det == '0) begin
            o_mid.status = segi_pkg::ST_PARALLEL;
        end else begin
            o_mid.status = segi_pkg::ST_HIT;
        end
    end

    assign o_mid_push = r_v;

endmodule

// ===== hdl/segi_back.sv =====
// Back end: crossing numerators, inclusive bounds check and a pipelined
// restoring divider, one quotient bit per stage. Depends on segi_pkg.
module segi_back #(
    parameter int OUT_DEPTH = 32,
    localparam int OCW = $clog2(OUT_DEPTH + 1)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_mid_empty,
    input  segi_pkg::t_mid     i_mid,
    output logic               o_mid_pop,
    input  logic [OCW-1:0]     i_out_count,
    output logic               o_out_push,
    output segi_pkg::t_seg_out o_out
);

    localparam int CB = segi_pkg::COORD_BITS;
    localparam int DW = segi_pkg::DIFF_W;
    localparam int LW = segi_pkg::LINE_W;
    localparam int TW = segi_pkg::DET_W;
    localparam int NW = segi_pkg::NUM_W;
    localparam int BW = segi_pkg::BND_W;

    // Issue control: words in flight plus words in the result queue never
    // exceed its depth, so the pipeline itself never stalls.
    logic [OCW-1:0] r_infl;
    logic [OCW:0]   used;
    logic           issue;
    logic           leave;

    assign used      = {1'b0, i_out_count} + {1'b0, r_infl};
    assign issue     = !i_mid_empty && (used < (OCW + 1)'(OUT_DEPTH));
    assign o_mid_pop = issue;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_infl <= '0;
        end else begin
            r_infl <= r_infl + OCW'(issue) - OCW'(leave);
        end
    end

    // Stage 1: numerators of the crossing point.
    logic signed [DW+LW-1:0] p_b2c1, p_b1c2, p_a1c2, p_a2c1;
    logic                    r1_v;
    logic [1:0]              r1_st;
    logic signed [CB-1:0]    r1_xlo, r1_xhi, r1_ylo, r1_yhi;
    logic signed [TW-1:0]    r1_det;
    logic signed [NW-1:0]    r1_nx, r1_ny;

    assign p_b2c1 = i_mid.b2 * i_mid.c1;
    assign p_b1c2 = i_mid.b1 * i_mid.c2;
    assign p_a1c2 = i_mid.a1 * i_mid.c2;
    assign p_a2c1 = i_mid.a2 * i_mid.c1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else begin
            r1_v <= issue;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_st  <= i_mid.status;
        r1_xlo <= i_mid.xlo;
        r1_xhi <= i_mid.xhi;
        r1_ylo <= i_mid.ylo;
        r1_yhi <= i_mid.yhi;
        r1_det <= i_mid.det;
        r1_nx  <= NW'(p_b2c1) - NW'(p_b1c2);
        r1_ny  <= NW'(p_a1c2) - NW'(p_a2c1);
    end

    // Stage 2: make the determinant positive, flip the numerators to match, and scale the box by it.
    logic                 dneg;
    logic signed [TW-1:0] dabs;
    logic                 r2_v;
    logic [1:0]           r2_st;
    logic signed [TW-1:0] r2_dabs;
    logic signed [NW-1:0] r2_nx, r2_ny;
    logic signed [BW-1:0] r2_pxlo, r2_pxhi, r2_pylo, r2_pyhi;

    assign dneg = r1_det[TW-1];
    assign dabs = dneg ? -r1_det : r1_det;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r2_st   <= r1_st;
        r2_dabs <= dabs;
        r2_nx   <= dneg ? -r1_nx : r1_nx;
        r2_ny   <= dneg ? -r1_ny : r1_ny;
        r2_pxlo <= r1_xlo * dabs;
        r2_pxhi <= r1_xhi * dabs;
        r2_pylo <= r1_ylo * dabs;
        r2_pyhi <= r1_yhi * dabs;
    end

    // Stage 3 is divider slot zero: bounds check and operand magnitudes.
    logic          r_dv_v  [0:CB];
    logic [1:0]    r_dv_st [0:CB];
    logic          r_dv_sx [0:CB];
    logic          r_dv_sy [0:CB];
    logic [NW-1:0] r_dv_rx [0:CB];
    logic [NW-1:0] r_dv_ry [0:CB];
    logic [CB-1:0] r_dv_qx [0:CB];
    logic [CB-1:0] r_dv_qy [0:CB];
    logic [TW-2:0] r_dv_d  [0:CB];

    logic          in_box;
    logic [NW-1:0] mag_x, mag_y;

    assign in_box = (NW'(r2_pxlo) <= r2_nx) && (r2_nx <= NW'(r2_pxhi)) &&
                    (NW'(r2_pylo) <= r2_ny) && (r2_ny <= NW'(r2_pyhi));
    assign mag_x  = r2_nx[NW-1] ? NW'(-r2_nx) : NW'(r2_nx);
    assign mag_y  = r2_ny[NW-1] ? NW'(-r2_ny) : NW'(r2_ny);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_v[0] <= 1'b0;
        end else begin
            r_dv_v[0] <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dv_st[0] <= (r2_st == segi_pkg::ST_HIT && !in_box) ?
                      segi_pkg::ST_OUTSIDE : r2_st;
        r_dv_sx[0] <= r2_nx[NW-1];
        r_dv_sy[0] <= r2_ny[NW-1];
        r_dv_rx[0] <= mag_x;
        r_dv_ry[0] <= mag_y;
        r_dv_qx[0] <= '0;
        r_dv_qy[0] <= '0;
        r_dv_d[0]  <= r2_dabs[TW-2:0];
    end

    // For a hit the quotient magnitude is below two to the coordinate width, so one
    // stage per quotient bit, most significant first, covers it.
    for (genvar j = 1; j <= CB; j++) begin : g_div
        logic [NW-1:0] sh;
        logic          ge_x, ge_y;

        assign sh   = NW'(r_dv_d[j-1]) << (CB - j);
        assign ge_x = (r_dv_rx[j-1] >= sh);
        assign ge_y = (r_dv_ry[j-1] >= sh);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_v[j] <= 1'b0;
            end else begin
                r_dv_v[j] <= r_dv_v[j-1];
            end
        end

        always_ff @(posedge i_clk) begin
            r_dv_st[j] <= r_dv_st[j-1];
            r_dv_sx[j] <= r_dv_sx[j-1];
            r_dv_sy[j] <= r_dv_sy[j-1];
            r_dv_rx[j] <= ge_x ? r_dv_rx[j-1] - sh : r_dv_rx[j-1];
            r_dv_ry[j] <= ge_y ? r_dv_ry[j-1] - sh : r_dv_ry[j-1];
            r_dv_qx[j] <= {r_dv_qx[j-1][CB-2:0], ge_x};
            r_dv_qy[j] <= {r_dv_qy[j-1][CB-2:0], ge_y};
            r_dv_d[j]  <= r_dv_d[j-1];
        end
    end

    // Result word: apply the quotient sign; only a hit carries a point.
    logic          hit;
    logic [CB-1:0] qx, qy;

    assign leave = r_dv_v[CB];
    assign hit   = (r_dv_st[CB] == segi_pkg::ST_HIT);
    assign qx    = r_dv_sx[CB] ? -r_dv_qx[CB] : r_dv_qx[CB];
    assign qy    = r_dv_sy[CB] ? -r_dv_qy[CB] : r_dv_qy[CB];

    assign o_out_push       = leave;
    assign o_out.hit_status = r_dv_st[CB];
    assign o_out.cross_x    = hit ? signed'(qx) : '0;
    assign o_out.cross_y    = hit ? signed'(qy) : '0;

endmodule

// ===== hdl/segment_intersection.sv =====
// Path from an accepted push to the result head: the input register, the
// classify queue, COORD_BITS + 3 stages and the result queue.
// Throughput: one word per cycle while the result queue is drained, as the divider is fully pipelined.
// Reset: synchronous, active low; it empties both queues and the pipeline.
// Depends on segi_pkg, segi_front, segi_fifo and segi_back.
module segment_intersection #(
    parameter int MID_DEPTH = 4,
    parameter int OUT_DEPTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    input  segi_pkg::t_seg_in  i_seg,
    output logic               full,
    input  logic               pop,
    output logic               empty,
    output segi_pkg::t_seg_out o_result
);

    localparam int MCW = $clog2(MID_DEPTH + 1);
    localparam int OCW = $clog2(OUT_DEPTH + 1);

    logic               mid_push;
    logic               mid_pop;
    logic               mid_empty;
    logic [MCW-1:0]     mid_count;
    segi_pkg::t_mid     mid_wr;
    segi_pkg::t_mid     mid_rd;
    logic               out_push;
    logic [OCW-1:0]     out_count;
    segi_pkg::t_seg_out out_wr;

    segi_front #(
        .MID_DEPTH (MID_DEPTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_seg       (i_seg),
        .o_full      (full),
        .i_mid_count (mid_count),
        .o_mid_push  (mid_push),
        .o_mid       (mid_wr)
    );

    segi_fifo #(
        .WIDTH ($bits(segi_pkg::t_mid)),
        .DEPTH (MID_DEPTH)
    ) u_midq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (mid_push),
        .i_wdata (mid_wr),
        .i_pop   (mid_pop),
        .o_rdata (mid_rd),
        .o_empty (mid_empty),
        .o_count (mid_count)
    );

    segi_back #(
        .OUT_DEPTH (OUT_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_mid_empty (mid_empty),
        .i_mid       (mid_rd),
        .o_mid_pop   (mid_pop),
        .i_out_count (out_count),
        .o_out_push  (out_push),
        .o_out       (out_wr)
    );

    segi_fifo #(
        .WIDTH ($bits(segi_pkg::t_seg_out)),
        .DEPTH (OUT_DEPTH)
    ) u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (out_push),
        .i_wdata (out_wr),
        .i_pop   (pop && !empty),
        .o_rdata (o_result),
        .o_empty (empty),
        .o_count (out_count)
    );

endmodule

// ===== hdl/segi_checker.sv =====
// Port-level checks for segment_intersection, attached by the bind below.
// Depends on segi_pkg.
module segi_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               push,
    input segi_pkg::t_seg_in  i_seg,
    input logic               full,
    input logic               pop,
    input logic               empty,
    input segi_pkg::t_seg_out o_result
);

    // Reset leaves both sides idle: nothing to read, room to write.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> empty && !full)
        else $error("queues not idle after reset");

    // Only a hit carries a crossing point.
    a_point_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result.hit_status != segi_pkg::ST_HIT) |->
        (o_result.cross_x == '0 && o_result.cross_y == '0))
        else $error("point reported without a hit");

    // A word that is not taken stays at the head unchanged.
    a_head_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_result)))
        else $error("result head changed while stalled");

    // Out of reset the queue flags are always driven to known values.
    a_flags_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$isunknown({full, empty}))
        else $error("queue flags unknown");

    // An accepted input word carries known coordinates.
    a_push_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !full) |-> !$isunknown(i_seg))
        else $error("unknown input word accepted");

endmodule

bind segment_intersection segi_checker u_chk (.*);
